// ===== hw/rtl/swsi_pkg.sv =====
`timescale 1ns / 1ps

package swsi_pkg;

	localparam int unsigned WOBBLE_DEPTH_DEF = 256;
	localparam int unsigned FIFO_DEPTH       = 2;
	localparam int unsigned ONE_Q30          = 32'd1 << 30;

	typedef enum logic [1:0] {
		OP_STEP    = 2'd0,
		OP_LOAD    = 2'd1,
		OP_RESTART = 2'd2,
		OP_NONE    = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		REG_START_X      = 2'd0,
		REG_START_Y      = 2'd1,
		REG_START_POWER  = 2'd2,
		REG_WOBBLE_COUNT = 2'd3
	} reg_idx_t;

	typedef enum logic [1:0] {
		KIND_STEP    = 2'd0,
		KIND_LOAD    = 2'd1,
		KIND_RESTART = 2'd2
	} kind_t;

	typedef struct packed {
		kind_t              kind;
		logic [7:0]         entry;
		logic signed [31:0] vx;
		logic signed [31:0] vy;
		logic signed [16:0] pd;
	} item_t;

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [16:0] p;
	} went_t;

	typedef struct packed {
		logic signed [31:0] start_x;
		logic signed [31:0] start_y;
		logic [15:0]        start_power;
		logic [8:0]         wobble_count;
	} cfg_t;

endpackage

// ===== hw/rtl/seam_wobble_superimposer.sv =====
`timescale 1ns / 1ps

// Seam wobble superimposer. Each step word carries one seam micro-vector; the
// block rotates the next wobble table vector onto the seam direction, adds it,
// advances the laser point and power, and returns the new point with the step
// length (Q16.16). Load words fill the wobble table (no result), restart
// words return the start point. A step runs one-bit normalizing shifts, two
// bit-serial square roots (seam radius and step length) and a restoring
// divider that forms cosine and sine together, plus products on the shared
// 33x33 multiplier. A zero seam vector skips the normalize, first root and
// divide. One word is worked on at a time; a two-word input queue and the
// output register keep both sides decoupled.
module seam_wobble_superimposer import swsi_pkg::*; #(
	parameter int unsigned WOBBLE_DEPTH = WOBBLE_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	// configuration writes
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	// input words
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         op,
	input  logic [7:0]         entry_index,
	input  logic signed [31:0] vec_x,
	input  logic signed [31:0] vec_y,
	input  logic signed [16:0] power_delta,
	// result words
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] pos_x,
	output logic signed [31:0] pos_y,
	output logic [15:0]        laser_power,
	output logic [31:0]        step_length,
	output logic               is_start
);

	cfg_t  cfg_q;
	logic  pop;
	logic  item_valid;
	item_t item;

	// registers are to be written only while idle (the user's duty, not enforced here), so no hold-off is needed
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_x      <= '0;
			cfg_q.start_y      <= '0;
			cfg_q.start_power  <= '0;
			cfg_q.wobble_count <= 9'd1;
		end else if (cfg_valid && cfg_ready) begin
			unique case (reg_idx_t'(cfg_index))
				REG_START_X:      cfg_q.start_x      <= cfg_data;
				REG_START_Y:      cfg_q.start_y      <= cfg_data;
				REG_START_POWER:  cfg_q.start_power  <= cfg_data[15:0];
				REG_WOBBLE_COUNT: cfg_q.wobble_count <= cfg_data[8:0];
				default: ;
			endcase
		end
	end

	// front: accept, classify, queue
	swsi_front #(
		.WOBBLE_DEPTH (WOBBLE_DEPTH)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.op          (op),
		.entry_index (entry_index),
		.vec_x       (vec_x),
		.vec_y       (vec_y),
		.power_delta (power_delta),
		.pop         (pop),
		.item_valid  (item_valid),
		.item        (item)
	);

	// back: table, rotation, accumulation, output register
	swsi_back #(
		.WOBBLE_DEPTH (WOBBLE_DEPTH)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.item_valid  (item_valid),
		.item        (item),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.pos_x       (pos_x),
		.pos_y       (pos_y),
		.laser_power (laser_power),
		.step_length (step_length),
		.is_start    (is_start)
	);

endmodule

// ===== hw/rtl/swsi_front.sv =====
`timescale 1ns / 1ps

module swsi_front import swsi_pkg::*; #(
	parameter int unsigned WOBBLE_DEPTH = WOBBLE_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         op,
	input  logic [7:0]         entry_index,
	input  logic signed [31:0] vec_x,
	input  logic signed [31:0] vec_y,
	input  logic signed [16:0] power_delta,
	input  logic               pop,
	output logic               item_valid,
	output item_t              item
);

	localparam int unsigned PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(FIFO_DEPTH + 1);

	item_t             buf_q [FIFO_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              accept;
	logic              keep;
	item_t             new_item;

	assign in_stall   = (cnt_q == CNT_W'(FIFO_DEPTH));
	assign accept     = in_valid && !in_stall;
	assign item_valid = (cnt_q != '0);
	assign item       = buf_q[rd_ptr_q];

	// classify: unknown ops and loads past the table are dropped here
	always_comb begin
		new_item.entry = entry_index;
		new_item.vx    = vec_x;
		new_item.vy    = vec_y;
		new_item.pd    = power_delta;
		new_item.kind  = KIND_STEP;
		keep           = 1'b0;
		unique case (op_t'(op))
			OP_STEP: begin
				new_item.kind = KIND_STEP;
				keep          = accept;
			end
			OP_LOAD: begin
				new_item.kind = KIND_LOAD;
				keep          = accept && (32'(entry_index) < WOBBLE_DEPTH);
			end
			OP_RESTART: begin
				new_item.kind = KIND_RESTART;
				keep          = accept;
			end
			default: keep = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (keep) begin
			buf_q[wr_ptr_q] <= new_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (keep) begin
				wr_ptr_q <= (32'(wr_ptr_q) == FIFO_DEPTH - 1) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (32'(rd_ptr_q) == FIFO_DEPTH - 1) ? '0 : rd_ptr_q + 1'b1;
			end
			if (keep && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !keep) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(cnt_q) <= FIFO_DEPTH)
		else $error("queue fill above depth");
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> cnt_q != '0)
		else $error("pop from empty queue");
	a_cnt_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!pop && !keep) |=> $stable(cnt_q))
		else $error("queue fill moved without push or pop");

endmodule

// ===== hw/rtl/swsi_back.sv =====
`timescale 1ns / 1ps

module swsi_back import swsi_pkg::*; #(
	parameter int unsigned WOBBLE_DEPTH = WOBBLE_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  cfg_t               cfg,
	input  logic               item_valid,
	input  item_t              item,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] pos_x,
	output logic signed [31:0] pos_y,
	output logic [15:0]        laser_power,
	output logic [31:0]        step_length,
	output logic               is_start
);

	localparam int unsigned IDX_W = (WOBBLE_DEPTH > 1) ? $clog2(WOBBLE_DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(WOBBLE_DEPTH + 1);

	typedef enum logic [11:0] {
		S_IDLE = 12'b0000_0000_0001,
		S_NORM = 12'b0000_0000_0010,
		S_SQ   = 12'b0000_0000_0100,
		S_ROOT = 12'b0000_0000_1000,
		S_DIVI = 12'b0000_0001_0000,
		S_DIV  = 12'b0000_0010_0000,
		S_SIGN = 12'b0000_0100_0000,
		S_MUL  = 12'b0000_1000_0000,
		S_RND  = 12'b0001_0000_0000,
		S_ADD  = 12'b0010_0000_0000,
		S_LEN  = 12'b0100_0000_0000,
		S_DONE = 12'b1000_0000_0000
	} state_t;

	state_t             state_q;
	logic [4:0]         cnt_q;
	logic               restart_q;
	logic               len_q;
	logic               sat_q;
	logic signed [31:0] vx_q, vy_q;
	logic [31:0]        ua_q, ub_q;
	logic signed [65:0] prod_q;
	logic [63:0]        acc_q;
	logic signed [63:0] accx_q, accy_q;
	logic [63:0]        sv_q, sr_q;
	logic [31:0]        remc_q, rems_q;
	logic [30:0]        numc_q, nums_q;
	logic [30:0]        qc_q, qs_q;
	logic signed [31:0] cs_q, sn_q;
	logic signed [34:0] rx_q, ry_q;
	logic signed [35:0] dx_q, dy_q;
	logic [31:0]        cur_x_q, cur_y_q;
	logic [15:0]        cur_pw_q;
	logic [IDX_W-1:0]   pos_q;
	logic [IDX_W-1:0]   idx_q;
	went_t              ent_q;
	went_t              mem [WOBBLE_DEPTH];

	logic               out_valid_q;
	logic signed [31:0] pos_x_q, pos_y_q;
	logic [15:0]        laser_power_q;
	logic [31:0]        step_length_q;
	logic               is_start_q;

	logic [CNT_W-1:0]   count_eff;
	logic [IDX_W-1:0]   idx_sel;
	logic [31:0]        idx_nxt;
	logic               out_free;
	logic signed [32:0] mop_a, mop_b;
	logic [64:0]        sq_sum;
	logic [63:0]        root_b;
	logic [64:0]        root_rb;
	logic [62:0]        nc_init, ns_init;
	logic [32:0]        tc, ts, dvs;
	logic [63:0]        magx, magy;
	logic [33:0]        mqx, mqy;
	logic [35:0]        adx, ady;
	logic signed [17:0] pw_sum;
	logic [15:0]        pw_sat;

	assign pop       = item_valid && (state_q == S_IDLE);
	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign pos_x       = pos_x_q;
	assign pos_y       = pos_y_q;
	assign laser_power = laser_power_q;
	assign step_length = step_length_q;
	assign is_start    = is_start_q;

	// count in use: zero acts as one, clipped to the table depth
	always_comb begin
		if (cfg.wobble_count == '0) begin
			count_eff = CNT_W'(1);
		end else if (32'(cfg.wobble_count) > WOBBLE_DEPTH) begin
			count_eff = CNT_W'(WOBBLE_DEPTH);
		end else begin
			count_eff = CNT_W'(cfg.wobble_count);
		end
		idx_sel = (32'(pos_q) < 32'(count_eff)) ? pos_q : '0;
		idx_nxt = 32'(idx_q) + 32'd1;
	end

	// shared multiplier operands
	always_comb begin
		mop_a = '0;
		mop_b = '0;
		if (state_q == S_SQ) begin
			mop_a = cnt_q[0] ? {1'b0, ub_q} : {1'b0, ua_q};
			mop_b = mop_a;
		end else begin
			unique case (cnt_q[1:0])
				2'd0: begin mop_a = 33'(cs_q); mop_b = 33'(ent_q.x); end
				2'd1: begin mop_a = 33'(sn_q); mop_b = 33'(ent_q.y); end
				2'd2: begin mop_a = 33'(sn_q); mop_b = 33'(ent_q.x); end
				default: begin mop_a = 33'(cs_q); mop_b = 33'(ent_q.y); end
			endcase
		end
	end

	always_comb begin
		sq_sum  = {1'b0, acc_q} + {1'b0, prod_q[63:0]};
		root_b  = 64'd1 << {cnt_q, 1'b0};
		root_rb = {1'b0, sr_q} + {1'b0, root_b};
		nc_init = {1'b0, ua_q, 30'd0} + 63'(sr_q[32:1]);
		ns_init = {1'b0, ub_q, 30'd0} + 63'(sr_q[32:1]);
		dvs     = {1'b0, sr_q[31:0]};
		tc      = {remc_q, numc_q[30]};
		ts      = {rems_q, nums_q[30]};
		// round to nearest, ties away from zero, by 2^30
		magx    = accx_q[63] ? 64'(-accx_q) : 64'(accx_q);
		magy    = accy_q[63] ? 64'(-accy_q) : 64'(accy_q);
		mqx     = 34'((magx + 64'(1 << 29)) >> 30);
		mqy     = 34'((magy + 64'(1 << 29)) >> 30);
		adx     = dx_q[35] ? 36'(-dx_q) : 36'(dx_q);
		ady     = dy_q[35] ? 36'(-dy_q) : 36'(dy_q);
		pw_sum  = $signed({2'b00, cur_pw_q}) + 18'(ent_q.p);
		if (pw_sum < 0) begin
			pw_sat = '0;
		end else if (pw_sum > 18'sd65535) begin
			pw_sat = 16'hFFFF;
		end else begin
			pw_sat = pw_sum[15:0];
		end
	end

	always_ff @(posedge clk) begin
		if (pop && item.kind == KIND_LOAD) begin
			mem[IDX_W'(item.entry)] <= '{x: item.vx, y: item.vy, p: item.pd};
		end
		if (pop && item.kind == KIND_STEP) begin
			ent_q <= mem[idx_sel];
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		prod_q <= mop_a * mop_b;
		unique case (state_q)
			S_IDLE: begin
				if (pop) begin
					vx_q    <= item.vx;
					vy_q    <= item.vy;
					ua_q    <= item.vx[31] ? 32'(-item.vx) : 32'(item.vx);
					ub_q    <= item.vy[31] ? 32'(-item.vy) : 32'(item.vy);
					idx_q   <= idx_sel;
					cs_q    <= 32'(ONE_Q30);
					sn_q    <= '0;
				end
			end
			S_NORM: begin
				if ((ua_q[31:30] | ub_q[31:30]) == 2'b00) begin
					ua_q <= ua_q << 1;
					ub_q <= ub_q << 1;
				end
			end
			S_SQ: begin
				if (cnt_q == 5'd1) begin
					acc_q <= prod_q[63:0];
				end
				if (cnt_q == 5'd2) begin
					sv_q <= sq_sum[63:0];
					sr_q <= '0;
				end
			end
			S_ROOT: begin
				if ({1'b0, sv_q} >= root_rb) begin
					sv_q <= sv_q - root_rb[63:0];
					sr_q <= (sr_q >> 1) + root_b;
				end else begin
					sr_q <= sr_q >> 1;
				end
			end
			S_DIVI: begin
				remc_q <= nc_init[62:31];
				numc_q <= nc_init[30:0];
				rems_q <= ns_init[62:31];
				nums_q <= ns_init[30:0];
				qc_q   <= '0;
				qs_q   <= '0;
			end
			S_DIV: begin
				if (tc >= dvs) begin
					remc_q <= 32'(tc - dvs);
					qc_q   <= {qc_q[29:0], 1'b1};
				end else begin
					remc_q <= tc[31:0];
					qc_q   <= {qc_q[29:0], 1'b0};
				end
				if (ts >= dvs) begin
					rems_q <= 32'(ts - dvs);
					qs_q   <= {qs_q[29:0], 1'b1};
				end else begin
					rems_q <= ts[31:0];
					qs_q   <= {qs_q[29:0], 1'b0};
				end
				numc_q <= numc_q << 1;
				nums_q <= nums_q << 1;
			end
			S_SIGN: begin
				cs_q <= vx_q[31] ? -$signed({1'b0, qc_q}) : $signed({1'b0, qc_q});
				sn_q <= vy_q[31] ? -$signed({1'b0, qs_q}) : $signed({1'b0, qs_q});
			end
			S_MUL: begin
				unique case (cnt_q)
					5'd1: accx_q <= prod_q[63:0];
					5'd2: accx_q <= accx_q - prod_q[63:0];
					5'd3: accy_q <= prod_q[63:0];
					5'd4: accy_q <= accy_q + prod_q[63:0];
					default: ;
				endcase
			end
			S_RND: begin
				rx_q <= accx_q[63] ? -$signed({1'b0, mqx}) : $signed({1'b0, mqx});
				ry_q <= accy_q[63] ? -$signed({1'b0, mqy}) : $signed({1'b0, mqy});
			end
			S_ADD: begin
				dx_q <= 36'(vx_q) + 36'(rx_q);
				dy_q <= 36'(vy_q) + 36'(ry_q);
			end
			S_LEN: begin
				ua_q <= adx[31:0];
				ub_q <= ady[31:0];
			end
			default: ;
		endcase
	end

	// output word registers
	always_ff @(posedge clk) begin
		if (state_q == S_DONE && out_free) begin
			if (restart_q) begin
				pos_x_q       <= cfg.start_x;
				pos_y_q       <= cfg.start_y;
				laser_power_q <= cfg.start_power;
				step_length_q <= '0;
				is_start_q    <= 1'b1;
			end else begin
				pos_x_q       <= cur_x_q + dx_q[31:0];
				pos_y_q       <= cur_y_q + dy_q[31:0];
				laser_power_q <= pw_sat;
				step_length_q <= sat_q ? 32'hFFFF_FFFF : sr_q[31:0];
				is_start_q    <= 1'b0;
			end
		end
	end

	// control and position state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			restart_q   <= 1'b0;
			len_q       <= 1'b0;
			sat_q       <= 1'b0;
			out_valid_q <= 1'b0;
			cur_x_q     <= '0;
			cur_y_q     <= '0;
			cur_pw_q    <= '0;
			pos_q       <= '0;
		end else begin
			if (state_q == S_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (pop) begin
						len_q     <= 1'b0;
						sat_q     <= 1'b0;
						restart_q <= (item.kind == KIND_RESTART);
						cnt_q     <= '0;
						unique case (item.kind)
							KIND_STEP: begin
								if (item.vx == '0 && item.vy == '0) begin
									state_q <= S_MUL;
								end else begin
									state_q <= S_NORM;
								end
							end
							KIND_RESTART: state_q <= S_DONE;
							default: state_q <= S_IDLE;
						endcase
					end
				end
				S_NORM: begin
					if ((ua_q[31:30] | ub_q[31:30]) != 2'b00) begin
						state_q <= S_SQ;
						cnt_q   <= '0;
					end
				end
				S_SQ: begin
					if (cnt_q == 5'd2) begin
						if (len_q && sq_sum[64]) begin
							sat_q   <= 1'b1;
							state_q <= S_DONE;
						end else begin
							state_q <= S_ROOT;
							cnt_q   <= 5'd31;
						end
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_ROOT: begin
					if (cnt_q == '0) begin
						state_q <= len_q ? S_DONE : S_DIVI;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				S_DIVI: begin
					state_q <= S_DIV;
					cnt_q   <= 5'd30;
				end
				S_DIV: begin
					if (cnt_q == '0) begin
						state_q <= S_SIGN;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				S_SIGN: begin
					state_q <= S_MUL;
					cnt_q   <= '0;
				end
				S_MUL: begin
					if (cnt_q == 5'd4) begin
						state_q <= S_RND;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_RND: state_q <= S_ADD;
				S_ADD: state_q <= S_LEN;
				S_LEN: begin
					len_q <= 1'b1;
					cnt_q <= '0;
					if (adx[35:32] != '0 || ady[35:32] != '0) begin
						sat_q   <= 1'b1;
						state_q <= S_DONE;
					end else begin
						state_q <= S_SQ;
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q     <= S_IDLE;
						if (restart_q) begin
							cur_x_q  <= cfg.start_x;
							cur_y_q  <= cfg.start_y;
							cur_pw_q <= cfg.start_power;
							pos_q    <= '0;
						end else begin
							cur_x_q  <= cur_x_q + dx_q[31:0];
							cur_y_q  <= cur_y_q + dy_q[31:0];
							cur_pw_q <= pw_sat;
							pos_q    <= (idx_nxt >= 32'(count_eff)) ? '0 : IDX_W'(idx_nxt);
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> (remc_q < sr_q[31:0] && rems_q < sr_q[31:0]))
		else $error("divider remainder not below divisor");
	a_quot_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SIGN) |-> (qc_q <= 31'(ONE_Q30) && qs_q <= 31'(ONE_Q30)))
		else $error("direction cosine above one");
	a_root_fit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && len_q && !sat_q) |-> sr_q[63:32] == '0)
		else $error("step length root wider than 32 bits");

endmodule

// ===== tb/tb_seam_wobble_superimposer.sv =====
`timescale 1ns / 1ps

module tb_seam_wobble_superimposer;
	import swsi_pkg::*;

	// One result word as it leaves the block.
	typedef struct {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic [15:0]        power;
		logic [31:0]        length;
		logic               start;
	} point_t;

	// Path predictor plus the queue of points still owed by the block.
	class point_tracker;
		logic signed [31:0] tbl_dx[256];
		logic signed [31:0] tbl_dy[256];
		logic signed [16:0] tbl_dp[256];
		logic signed [31:0] home_x, home_y, pos_x, pos_y;
		logic [15:0]        home_power, power;
		logic [8:0]         count_reg;
		int unsigned        wpos;
		point_t             owed[$];
		int                 errors;

		function new();
			home_x = 0; home_y = 0; home_power = 0; count_reg = 1;
			pos_x = 0; pos_y = 0; power = 0; wpos = 0; errors = 0;
		endfunction

		function void set_reg(reg_idx_t idx, logic [31:0] data);
			case (idx)
				REG_START_X:      home_x = data;
				REG_START_Y:      home_y = data;
				REG_START_POWER:  home_power = data[15:0];
				REG_WOBBLE_COUNT: count_reg = data[8:0];
			endcase
		endfunction

		static function longint unsigned isqrt(longint unsigned v);
			longint unsigned r = 0;
			longint unsigned b = 64'h4000_0000_0000_0000;
			while (b > v) b >>= 2;
			while (b != 0) begin
				if (v >= r + b) begin
					v -= r + b;
					r = (r >> 1) + b;
				end else begin
					r >>= 1;
				end
				b >>= 2;
			end
			return r;
		endfunction

		static function longint unsigned mag(longint v);
			return (v < 0) ? longint'(-v) : longint'(v);
		endfunction

		// divide by 2^30, round half away from zero
		static function longint round_q30(longint num);
			longint unsigned q;
			q = (mag(num) + 64'd536870912) >> 30;
			return (num < 0) ? -longint'(q) : longint'(q);
		endfunction

		// Work out the effect of one accepted input word.
		function void take_word(op_t op, logic [7:0] entry, logic signed [31:0] vx,
				logic signed [31:0] vy, logic signed [16:0] pd);
			int unsigned cnt, idx;
			longint unsigned ax, ay, m, r, a, b, sum;
			longint cs, sn, wx, wy, dx, dy, pw;
			int k;
			point_t p;
			case (op)
				OP_LOAD: begin
					tbl_dx[entry] = vx;
					tbl_dy[entry] = vy;
					tbl_dp[entry] = pd;
				end
				OP_RESTART: begin
					pos_x = home_x; pos_y = home_y; power = home_power; wpos = 0;
					p.x = pos_x; p.y = pos_y; p.power = power; p.length = 0; p.start = 1;
					owed = {owed, p};
				end
				OP_STEP: begin
					cnt = 32'(count_reg);
					if (cnt == 0) cnt = 1;
					if (cnt > 256) cnt = 256;
					idx = (wpos < cnt) ? wpos : 0;
					wx = longint'(tbl_dx[idx]);
					wy = longint'(tbl_dy[idx]);
					cs = 64'sd1 << 30;
					sn = 0;
					if (vx != 0 || vy != 0) begin
						ax = mag(longint'(vx));
						ay = mag(longint'(vy));
						m = (ax > ay) ? ax : ay;
						k = 0;
						while ((m << k) < (64'd1 << 30)) k++;
						ax <<= k;
						ay <<= k;
						r = isqrt(ax * ax + ay * ay);
						cs = ((ax << 30) + r / 2) / r;
						sn = ((ay << 30) + r / 2) / r;
						if (vx < 0) cs = -cs;
						if (vy < 0) sn = -sn;
					end
					dx = longint'(vx) + round_q30(cs * wx - sn * wy);
					dy = longint'(vy) + round_q30(sn * wx + cs * wy);
					pos_x = pos_x + dx[31:0];
					pos_y = pos_y + dy[31:0];
					pw = longint'(power) + longint'(tbl_dp[idx]);
					if (pw < 0) pw = 0;
					if (pw > 65535) pw = 65535;
					power = pw[15:0];
					wpos = (idx + 1 >= cnt) ? 0 : idx + 1;
					// length saturates once the squares leave 64 bits
					a = mag(dx);
					b = mag(dy);
					if (a >= (64'd1 << 32) || b >= (64'd1 << 32)) begin
						p.length = 32'hFFFF_FFFF;
					end else begin
						sum = a * a + b * b;
						p.length = (sum < a * a) ? 32'hFFFF_FFFF : 32'(isqrt(sum));
					end
					p.x = pos_x; p.y = pos_y; p.power = power; p.start = 0;
					owed = {owed, p};
				end
				default: ;
			endcase
		endfunction

		function void match_point(point_t got);
			point_t exp;
			if (owed.size() == 0) begin
				$error("point word with nothing owed");
				errors++;
				return;
			end
			exp = owed.pop_front();
			if (got.x !== exp.x) begin
				$error("pos_x: expected %0d, got %0d", exp.x, got.x); errors++;
			end
			if (got.y !== exp.y) begin
				$error("pos_y: expected %0d, got %0d", exp.y, got.y); errors++;
			end
			if (got.power !== exp.power) begin
				$error("laser_power: expected %0d, got %0d", exp.power, got.power); errors++;
			end
			if (got.length !== exp.length) begin
				$error("step_length: expected %0d, got %0d", exp.length, got.length); errors++;
			end
			if (got.start !== exp.start) begin
				$error("is_start: expected %0d, got %0d", exp.start, got.start); errors++;
			end
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [1:0]         cfg_index;
	logic [31:0]        cfg_data;
	logic               in_valid;
	logic               in_stall;
	logic [1:0]         op;
	logic [7:0]         entry_index;
	logic signed [31:0] vec_x;
	logic signed [31:0] vec_y;
	logic signed [16:0] power_delta;
	logic               out_valid;
	logic               out_stall;
	logic signed [31:0] pos_x;
	logic signed [31:0] pos_y;
	logic [15:0]        laser_power;
	logic [31:0]        step_length;
	logic               is_start;

	seam_wobble_superimposer dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.op(op), .entry_index(entry_index), .vec_x(vec_x), .vec_y(vec_y),
		.power_delta(power_delta),
		.out_valid(out_valid), .out_stall(out_stall),
		.pos_x(pos_x), .pos_y(pos_y), .laser_power(laser_power),
		.step_length(step_length), .is_start(is_start)
	);

	point_tracker tracker = new();
	int unsigned  send_idle_pct = 0;  // chance per cycle that the sender holds off
	int unsigned  recv_stall_pct = 0; // chance per cycle that the receiver stalls
	int unsigned  quiet_cycles = 0;   // cycles since the last handshake of any kind

	localparam int unsigned QUIET_LIMIT = 20000;
	localparam int unsigned SETTLE      = 200;

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	// Receiver: random stall, fresh draw every cycle.
	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	// Result monitor; values sampled here are the ones present at the edge.
	always @(posedge clk) begin
		point_t got;
		if (arst_n && out_valid && !out_stall) begin
			got.x = pos_x; got.y = pos_y; got.power = laser_power;
			got.length = step_length; got.start = is_start;
			tracker.match_point(got);
		end
	end

	// Watchdog: any handshake counts as progress.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
				(cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("[seam_wobble_superimposer] ERROR");
			$finish;
		end
	end

	// Config writes happen only with the block idle; the caller drops valid.
	task automatic write_reg(reg_idx_t idx, logic [31:0] data);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		tracker.set_reg(idx, data);
	endtask

	task automatic send_word(op_t o, logic [7:0] e, logic signed [31:0] x,
			logic signed [31:0] y, logic signed [16:0] pd);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid    <= 1;
		op          <= o;
		entry_index <= e;
		vec_x       <= x;
		vec_y       <= y;
		power_delta <= pd;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		tracker.take_word(o, e, x, y, pd);
	endtask

	// Wait for all owed points, then give loads and ignored words time to retire.
	task automatic drain();
		in_valid <= 0;
		while (tracker.owed.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// Vectors spread over all magnitudes, with zero and the rails now and then.
	function automatic logic signed [31:0] any_vec();
		case ($urandom_range(9))
			0: return 0;
			1: return 32'sh7FFF_FFFF;
			2: return 32'sh8000_0000;
			default: return $signed($urandom) >>> $urandom_range(0, 28);
		endcase
	endfunction

	function automatic logic signed [16:0] any_pd();
		case ($urandom_range(7))
			0: return 17'sd65535;
			1: return -17'sd65535;
			2: return 17'sh10000;
			default: return $signed(17'($urandom)) >>> $urandom_range(0, 12);
		endcase
	endfunction

	// Random traffic: mostly steps over a loaded figure, some reloads, restarts and unknown ops.
	task automatic random_traffic(int unsigned n);
		int unsigned done;
		int unsigned pick;
		done = 0;
		while (done < n) begin
			pick = $urandom_range(99);
			if (pick < 74)
				send_word(OP_STEP, 8'($urandom), any_vec(), any_vec(), 17'($urandom));
			else if (pick < 88)
				send_word(OP_LOAD, 8'($urandom), any_vec(), any_vec(), any_pd());
			else if (pick < 95)
				send_word(OP_RESTART, 8'($urandom), $urandom, $urandom, 17'($urandom));
			else
				send_word(OP_NONE, 8'($urandom), $urandom, $urandom, 17'($urandom));
			if (pick < 95) done++;
		end
	endtask

	task automatic configure(logic [31:0] sx, logic [31:0] sy, logic [15:0] sp,
			logic [8:0] cnt);
		write_reg(REG_START_X, sx);
		write_reg(REG_START_Y, sy);
		write_reg(REG_START_POWER, {16'd0, sp});
		write_reg(REG_WOBBLE_COUNT, {23'd0, cnt});
		cfg_valid <= 0;
	endtask

	initial begin
		arst_n      <= 0;
		cfg_valid   <= 0;
		cfg_index   <= REG_START_X;
		cfg_data    <= 0;
		in_valid    <= 0;
		op          <= OP_NONE;
		entry_index <= 0;
		vec_x       <= 0;
		vec_y       <= 0;
		power_delta <= 0;
		out_stall   <= 0;
		repeat (4) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Fill the whole table first so no step ever reads an unwritten entry.
		for (int i = 0; i < 256; i++)
			send_word(OP_LOAD, 8'(i), any_vec(), any_vec(), any_pd());

		// Directed: restart from reset values, then the corner steps.
		send_word(OP_RESTART, 0, 0, 0, 0);
		send_word(OP_STEP, 0, 0, 0, 0);  // zero seam: wobble passes unrotated
		send_word(OP_LOAD, 0, 32'sh7FFF_FFFF, 32'sh8000_0000, 17'sd65535);
		send_word(OP_STEP, 0, 32'sh7FFF_FFFF, 32'sh8000_0000, 0);
		send_word(OP_STEP, 0, 32'sh8000_0000, 0, 0);
		send_word(OP_LOAD, 0, 32'sh8000_0000, 32'sh8000_0000, 17'sh10000);
		send_word(OP_STEP, 0, 1, 0, 0);
		send_word(OP_STEP, 0, 0, -1, 0);
		send_word(OP_LOAD, 255, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, -17'sd65535);
		send_word(OP_STEP, 0, 32'sh8000_0000, 32'sh7FFF_FFFF, 0);
		send_word(OP_NONE, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 17'h1FFFF);
		send_word(OP_STEP, 0, -3, 5, 0);
		send_word(OP_RESTART, 0, 0, 0, 0);
		drain();

		// Phases: each with its own pacing and register set.
		// Count 0 acts as 1, 511 as full depth; dropping to 3 after a long run
		// leaves a stale table position behind.
		configure(32'h7FFF_FFFF, 32'h8000_0000, 16'hFFFF, 9'd256);
		send_idle_pct = 0; recv_stall_pct = 0;
		random_traffic(280);
		drain();

		configure($urandom, $urandom, 16'd0, 9'd3);
		send_idle_pct = 67; recv_stall_pct = 0;
		random_traffic(280);
		drain();

		configure(32'h8000_0000, 32'h7FFF_FFFF, 16'($urandom), 9'd0);
		send_idle_pct = 0; recv_stall_pct = 67;
		random_traffic(280);
		drain();

		configure($urandom, $urandom, 16'($urandom), 9'd511);
		send_idle_pct = 25; recv_stall_pct = 25;
		random_traffic(160);
		drain();

		configure(0, 0, 16'($urandom), 9'($urandom_range(1, 256)));
		send_idle_pct = 0; recv_stall_pct = 0;
		random_traffic(130);
		drain();

		if (tracker.errors == 0)
			$display("[seam_wobble_superimposer] OK");
		else
			$display("[seam_wobble_superimposer] ERROR");
		$finish;
	end

endmodule

// ===== filelist.f =====
hw/rtl/swsi_pkg.sv
hw/rtl/swsi_front.sv
hw/rtl/swsi_back.sv
hw/rtl/seam_wobble_superimposer.sv
tb/tb_seam_wobble_superimposer.sv
